### sv/sfe_pkg.sv
// ---------------------------------------------------------------------------
// sfe_pkg: shared constants and types of the S.BUS frame encoder
// Frame layout, channel geometry, pulse width scaling constants and the
// action codes carried on the input channel.
// ---------------------------------------------------------------------------
package sfe_pkg;

  // Channel store geometry.
  localparam int unsigned NUM_CHANNELS = 16;
  localparam int unsigned SLOT_COUNT   = 16;
  localparam int unsigned SLOT_W       = $clog2(SLOT_COUNT);
  localparam int unsigned CH_BITS      = 11;
  localparam int unsigned STREAM_BITS  = SLOT_COUNT * CH_BITS;

  // Frame layout.
  localparam int unsigned PACK_BYTES = STREAM_BITS / 8;
  localparam int unsigned FRAME_LEN  = PACK_BYTES + 3;
  localparam int unsigned CNT_W      = $clog2(FRAME_LEN);

  localparam logic [7:0] START_BYTE = 8'h0F;
  localparam logic [7:0] END_BYTE   = 8'h00;

  localparam logic [CNT_W-1:0] IDX_START = CNT_W'(0);
  localparam logic [CNT_W-1:0] IDX_PACK0 = CNT_W'(1);
  localparam logic [CNT_W-1:0] IDX_PACKN = CNT_W'(PACK_BYTES);
  localparam logic [CNT_W-1:0] IDX_FLAGS = CNT_W'(PACK_BYTES + 1);
  localparam logic [CNT_W-1:0] IDX_END   = CNT_W'(FRAME_LEN - 1);

  // Pulse width mapping: (w - 880) * 2047 / 1280, with 1280 = 256 * 5.
  localparam int unsigned WIDTH_MIN   = 880;
  localparam int unsigned WIDTH_MAX   = 2160;
  localparam int unsigned RAW_MAX     = 2047;
  localparam int unsigned SCALE_SHIFT = 8;
  localparam int unsigned RECIP_5     = 52429;
  localparam int unsigned RECIP_SHIFT = 18;
  localparam int unsigned MUL_A_W     = 14;
  localparam int unsigned MUL_B_W     = 16;
  localparam int unsigned PROD_W      = MUL_A_W + MUL_B_W;

  // Action codes.
  typedef enum logic [1:0] {
    ACT_RAW   = 2'd0,
    ACT_WIDTH = 2'd1,
    ACT_FLAG  = 2'd2,
    ACT_SEND  = 2'd3
  } action_e;

endpackage

### sv/sbus_frame_encoder_unit.sv
// ---------------------------------------------------------------------------
// sbus_frame_encoder_unit: S.BUS frame encoder with a shared scaling multiplier
// Stores sixteen 11-bit servo channels and four flags, and streams the
// 25-byte S.BUS frame on request, one word per cycle unless the output stalls.
// ---------------------------------------------------------------------------
// Usage. Commands arrive as words on the input channel (in_valid_i/in_ready_o).
// A raw write or a flag write is absorbed in the cycle it is accepted and the
// block is ready again in the next cycle. A pulse width write has the accept
// cycle, then two passes through one shared multiplier (scale by 2047, then
// divide by 1280 as a shift and a reciprocal multiply), and the channel is
// written at the end of the second pass.
// A send command produces 25 words on the output channel (out_valid_o/
// out_ready_i): the start byte, 22 packed channel bytes, the flags byte and
// the end byte, which carries last_o. The first word enters the output
// register from the send state once that register is free, and without
// backpressure one word leaves per cycle; the rate is set by the single output
// register that is loaded from a 176-bit shift register, eight bits per word.
// When the receiver stalls, the output register holds its word and the frame
// simply pauses. The block takes the next command as soon as the last word is
// in the output register, even while that word still waits to be taken.
// Reset clears all channels and flags to zero and empties the output.
// ---------------------------------------------------------------------------
module sbus_frame_encoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  channel_i,
  input  logic [15:0] value_i,
  input  logic [1:0]  flag_select_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  frame_byte_o,
  output logic        last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_RECIP,
    ST_SEND
  } state_e;

  localparam int unsigned CH_W = sfe_pkg::CH_BITS;
  localparam int unsigned SW   = sfe_pkg::SLOT_W;

  state_e                              state_q;
  logic [CH_W-1:0]                     chan_q [sfe_pkg::SLOT_COUNT];
  logic [3:0]                          flag_bits_q;
  logic [SW-1:0]                       slot_q;
  logic [CH_W-1:0]                     delta_q;
  logic [sfe_pkg::PROD_W-1:0]          prod_q;
  logic [sfe_pkg::STREAM_BITS-1:0]     stream_q;
  logic [sfe_pkg::CNT_W-1:0]           cnt_q;
  logic [7:0]                          byte_q;
  logic                                last_q;
  logic                                out_valid_q;

  logic                                accept;
  logic                                chan_ok;
  logic [SW-1:0]                       slot_in;
  logic [15:0]                         width_clamped;
  logic [sfe_pkg::MUL_A_W-1:0]         mul_a;
  logic [sfe_pkg::MUL_B_W-1:0]         mul_b;
  logic [sfe_pkg::PROD_W-1:0]          product;
  logic [sfe_pkg::STREAM_BITS-1:0]     stream_d;
  logic                                out_free;
  logic                                load_out;
  logic [7:0]                          byte_d;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign accept       = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = byte_q;
  assign last_o       = last_q;
  assign out_free     = !out_valid_q || out_ready_i;
  // A new frame word enters the output register in this cycle.
  assign load_out     = (state_q == ST_SEND) && out_free;

  assign chan_ok = (channel_i >= 8'd1) && (channel_i <= 8'(sfe_pkg::NUM_CHANNELS));
  assign slot_in = SW'(channel_i - 8'd1);

  always_comb begin
    if (value_i < 16'(sfe_pkg::WIDTH_MIN)) begin
      width_clamped = 16'(sfe_pkg::WIDTH_MIN);
    end else if (value_i > 16'(sfe_pkg::WIDTH_MAX)) begin
      width_clamped = 16'(sfe_pkg::WIDTH_MAX);
    end else begin
      width_clamped = value_i;
    end
  end

  // The one multiplier: first pass scales by 2047, second pass divides the
  // scaled value, already shifted down by 256, by five through its reciprocal.
  always_comb begin
    if (state_q == ST_RECIP) begin
      mul_a = prod_q[sfe_pkg::SCALE_SHIFT +: sfe_pkg::MUL_A_W];
      mul_b = sfe_pkg::MUL_B_W'(sfe_pkg::RECIP_5);
    end else begin
      mul_a = sfe_pkg::MUL_A_W'(delta_q);
      mul_b = sfe_pkg::MUL_B_W'(sfe_pkg::RAW_MAX);
    end
  end
  assign product = sfe_pkg::PROD_W'(mul_a) * sfe_pkg::PROD_W'(mul_b);

  // Channel 1 sits at the top of the stream, each channel MSB first.
  always_comb begin
    for (int s = 0; s < int'(sfe_pkg::SLOT_COUNT); s++) begin
      stream_d[sfe_pkg::STREAM_BITS - 1 - s * CH_W -: CH_W] = chan_q[s];
    end
  end

  always_comb begin
    case (cnt_q) inside
      sfe_pkg::IDX_START:                          byte_d = sfe_pkg::START_BYTE;
      [sfe_pkg::IDX_PACK0:sfe_pkg::IDX_PACKN]:     byte_d =
          stream_q[sfe_pkg::STREAM_BITS-1 -: 8];
      sfe_pkg::IDX_FLAGS:                          byte_d = {flag_bits_q, 4'b0000};
      default:                                     byte_d = sfe_pkg::END_BYTE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      flag_bits_q <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      slot_q      <= '0;
      delta_q     <= '0;
      prod_q      <= '0;
      stream_q    <= '0;
      byte_q      <= '0;
      last_q      <= 1'b0;
      for (int s = 0; s < int'(sfe_pkg::SLOT_COUNT); s++) begin
        chan_q[s] <= '0;
      end
    end else begin
      if (out_valid_q && out_ready_i && !load_out) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (sfe_pkg::action_e'(action_i))
              sfe_pkg::ACT_RAW: begin
                if (chan_ok) begin
                  chan_q[slot_in] <= value_i[CH_W-1:0];
                end
              end
              sfe_pkg::ACT_WIDTH: begin
                if (chan_ok) begin
                  slot_q  <= slot_in;
                  delta_q <= CH_W'(width_clamped - 16'(sfe_pkg::WIDTH_MIN));
                  state_q <= ST_SCALE;
                end
              end
              sfe_pkg::ACT_FLAG: begin
                flag_bits_q[2'd3 - flag_select_i] <= (value_i != 16'd0);
              end
              default: begin
                stream_q <= stream_d;
                cnt_q    <= sfe_pkg::IDX_START;
                state_q  <= ST_SEND;
              end
            endcase
          end
        end
        ST_SCALE: begin
          prod_q  <= product;
          state_q <= ST_RECIP;
        end
        ST_RECIP: begin
          chan_q[slot_q] <= product[sfe_pkg::RECIP_SHIFT +: CH_W];
          state_q        <= ST_IDLE;
        end
        ST_SEND: begin
          if (out_free) begin
            byte_q      <= byte_d;
            last_q      <= (cnt_q == sfe_pkg::IDX_END);
            out_valid_q <= 1'b1;
            if ((cnt_q >= sfe_pkg::IDX_PACK0) && (cnt_q <= sfe_pkg::IDX_PACKN)) begin
              stream_q <= {stream_q[sfe_pkg::STREAM_BITS-9:0], 8'h00};
            end
            if (cnt_q == sfe_pkg::IDX_END) begin
              state_q <= ST_IDLE;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### dv/sbus_frame_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sbus_frame_checker: frame predictor and word comparator
// Follows every command word taken by the encoder, keeps its own copy of the
// servo channels and flags, and lays out the expected 25-byte frame for each
// send. Every word leaving the encoder is compared with the oldest expected
// word, and the failures are counted for the testbench top.
// ---------------------------------------------------------------------------
module sbus_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  action_i,
  input  logic [7:0]  channel_i,
  input  logic [15:0] value_i,
  input  logic [1:0]  flag_select_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  frame_byte_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_word_t;

  logic [sfe_pkg::CH_BITS-1:0] servo_q [sfe_pkg::SLOT_COUNT];
  // Indexed by the flag select code; the frame carries them from bit 7 down.
  logic               flag_q  [4];
  frame_word_t        expected_words [$];
  frame_word_t        oldest;

  // Clamp to the legal pulse range, then scale onto the 11-bit channel range.
  function automatic logic [sfe_pkg::CH_BITS-1:0] width_to_raw(logic [15:0] pulse_width);
    int unsigned w;
    w = pulse_width;
    if (w < sfe_pkg::WIDTH_MIN) w = sfe_pkg::WIDTH_MIN;
    if (w > sfe_pkg::WIDTH_MAX) w = sfe_pkg::WIDTH_MAX;
    return sfe_pkg::CH_BITS'((w - sfe_pkg::WIDTH_MIN) * sfe_pkg::RAW_MAX /
                             (sfe_pkg::WIDTH_MAX - sfe_pkg::WIDTH_MIN));
  endfunction

  // Channel 1 sits in the top bits of the stream, each channel MSB first.
  task automatic queue_frame();
    logic [sfe_pkg::STREAM_BITS-1:0] stream;
    for (int s = 0; s < sfe_pkg::SLOT_COUNT; s++) begin
      stream[sfe_pkg::STREAM_BITS-1-s*sfe_pkg::CH_BITS -: sfe_pkg::CH_BITS] = servo_q[s];
    end
    expected_words.push_back('{sfe_pkg::START_BYTE, 1'b0});
    for (int b = 0; b < sfe_pkg::PACK_BYTES; b++) begin
      expected_words.push_back('{stream[sfe_pkg::STREAM_BITS-1-8*b -: 8], 1'b0});
    end
    expected_words.push_back('{{flag_q[0], flag_q[1], flag_q[2], flag_q[3], 4'b0000}, 1'b0});
    expected_words.push_back('{sfe_pkg::END_BYTE, 1'b1});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (servo_q[i]) servo_q[i] = '0;
      foreach (flag_q[i]) flag_q[i] = 1'b0;
      expected_words.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $error("frame_byte: expected no word, got %h", frame_byte_i);
          fail_count_o++;
        end else begin
          oldest = expected_words.pop_front();
          if (frame_byte_i !== oldest.data) begin
            $error("frame_byte: expected %h, got %h", oldest.data, frame_byte_i);
            fail_count_o++;
          end
          if (last_i !== oldest.last) begin
            $error("last: expected %b, got %b", oldest.last, last_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (sfe_pkg::action_e'(action_i))
          sfe_pkg::ACT_RAW: begin
            if (channel_i >= 1 && channel_i <= sfe_pkg::NUM_CHANNELS)
              servo_q[channel_i-1] = value_i[sfe_pkg::CH_BITS-1:0];
          end
          sfe_pkg::ACT_WIDTH: begin
            if (channel_i >= 1 && channel_i <= sfe_pkg::NUM_CHANNELS)
              servo_q[channel_i-1] = width_to_raw(value_i);
          end
          sfe_pkg::ACT_FLAG: begin
            flag_q[flag_select_i] = (value_i != '0);
          end
          default: begin
            queue_frame();
          end
        endcase
      end
      pending_o = expected_words.size();
    end
  end

endmodule

### dv/sbus_frame_encoder_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sbus_frame_encoder_unit_tb: testbench top of the S.BUS frame encoder
// Drives command words into the encoder, pulls frame words out under random
// backpressure, and lets the frame checker predict and compare every word.
// ---------------------------------------------------------------------------
module sbus_frame_encoder_unit_tb;

  // Flag select codes as the encoder decodes them.
  localparam logic [1:0] FLAG_CH17     = 2'd0;
  localparam logic [1:0] FLAG_CH18     = 2'd1;
  localparam logic [1:0] FLAG_LOST     = 2'd2;
  localparam logic [1:0] FLAG_FAILSAFE = 2'd3;

  // Random words per idling phase, after the directed opening.
  localparam int PHASE_WORDS = 120;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i      = '0;
  logic [7:0]  channel_i     = '0;
  logic [15:0] value_i       = '0;
  logic [1:0]  flag_select_i = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [7:0]  frame_byte_o;
  logic        last_o;

  int fail_count;
  int pending_words;

  // Percentages of cycles in which the sender holds back a word and in which
  // the receiver refuses one. Changed between phases by the stimulus.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  sbus_frame_encoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .channel_i     (channel_i),
    .value_i       (value_i),
    .flag_select_i (flag_select_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .frame_byte_o  (frame_byte_o),
    .last_o        (last_o)
  );

  // The checker sees both channels exactly as the encoder does and reports
  // its failure count and the number of frame words still owed.
  sbus_frame_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .action_i      (action_i),
    .channel_i     (channel_i),
    .value_i       (value_i),
    .flag_select_i (flag_select_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .frame_byte_i  (frame_byte_o),
    .last_i        (last_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending_words)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // This limit leaves a wide margin over the slowest correct run while still
  // catching a hung handshake.
  initial begin
    #400000;
    $display("sbus_frame_encoder_unit test failed");
    $finish;
  end

  // The receiver decides afresh every cycle whether it takes a word, so the
  // stalls land on every byte position of the frame.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Presents one command word and holds it until the encoder takes it. After
  // the accept the sender may go quiet for a random number of cycles; when it
  // does not, valid simply stays high into the next word.
  task automatic issue_word(sfe_pkg::action_e act, logic [7:0] ch, logic [15:0] val,
                            logic [1:0] fsel);
    in_valid_i    <= 1'b1;
    action_i      <= act;
    channel_i     <= ch;
    value_i       <= val;
    flag_select_i <= fsel;
    do @(posedge clk_i); while (!in_ready_o);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // One random command. Most writes hit real channels, most width values
  // lie near the legal pulse range, so frames carry rich content; the rest
  // hits channels outside the range, clamped widths and full 16-bit values.
  task automatic issue_random_word();
    int          pick;
    logic [7:0]  ch;
    logic [15:0] val;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 85) ch = 8'($urandom_range(1, sfe_pkg::NUM_CHANNELS));
    else ch = 8'($urandom_range(0, 255));
    if (pick < 30) begin
      issue_word(sfe_pkg::ACT_RAW, ch, 16'($urandom_range(0, 65535)),
                 2'($urandom_range(0, 3)));
    end else if (pick < 55) begin
      if ($urandom_range(99) < 80) val = 16'($urandom_range(800, 2240));
      else val = 16'($urandom_range(0, 65535));
      issue_word(sfe_pkg::ACT_WIDTH, ch, val, 2'($urandom_range(0, 3)));
    end else if (pick < 70) begin
      if ($urandom_range(1) == 0) val = '0;
      else val = 16'($urandom_range(1, 65535));
      issue_word(sfe_pkg::ACT_FLAG, 8'($urandom_range(0, 255)), val,
                 2'($urandom_range(0, 3)));
    end else begin
      // The send ignores the other fields, so they carry noise.
      issue_word(sfe_pkg::ACT_SEND, 8'($urandom_range(0, 255)),
                 16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A frame straight after reset must show all channels and flags at zero.
    issue_word(sfe_pkg::ACT_SEND, 8'd0, 16'd0, FLAG_CH17);

    // Raw writes at the channel range ends; bits above the eleventh are
    // dropped, and writes to channel zero or above sixteen are ignored.
    issue_word(sfe_pkg::ACT_RAW, 8'd1, 16'hFFFF, FLAG_CH17);
    issue_word(sfe_pkg::ACT_RAW, 8'd16, 16'h07FF, FLAG_CH17);
    issue_word(sfe_pkg::ACT_RAW, 8'd0, 16'h1234, FLAG_CH17);
    issue_word(sfe_pkg::ACT_RAW, 8'd17, 16'h0555, FLAG_CH17);
    issue_word(sfe_pkg::ACT_RAW, 8'd255, 16'h02AA, FLAG_CH17);
    issue_word(sfe_pkg::ACT_FLAG, 8'd0, 16'hFFFF, FLAG_CH17);
    issue_word(sfe_pkg::ACT_FLAG, 8'd200, 16'd1, FLAG_LOST);
    issue_word(sfe_pkg::ACT_SEND, 8'd255, 16'hFFFF, FLAG_FAILSAFE);

    // Pulse widths below, at and above the clamp limits, and mid scale.
    issue_word(sfe_pkg::ACT_WIDTH, 8'd2, 16'd0, FLAG_CH17);
    issue_word(sfe_pkg::ACT_WIDTH, 8'd3, 16'd879, FLAG_CH17);
    issue_word(sfe_pkg::ACT_WIDTH, 8'd4, 16'd880, FLAG_CH17);
    issue_word(sfe_pkg::ACT_WIDTH, 8'd5, 16'd2160, FLAG_CH17);
    issue_word(sfe_pkg::ACT_WIDTH, 8'd6, 16'd2161, FLAG_CH17);
    issue_word(sfe_pkg::ACT_WIDTH, 8'd7, 16'hFFFF, FLAG_CH17);
    issue_word(sfe_pkg::ACT_WIDTH, 8'd8, 16'd1520, FLAG_CH17);
    issue_word(sfe_pkg::ACT_WIDTH, 8'd0, 16'd1500, FLAG_CH17);
    issue_word(sfe_pkg::ACT_WIDTH, 8'd200, 16'd1500, FLAG_CH17);

    // Remaining flags set, then one cleared again by a zero value.
    issue_word(sfe_pkg::ACT_FLAG, 8'd5, 16'h8000, FLAG_CH18);
    issue_word(sfe_pkg::ACT_FLAG, 8'd0, 16'h0001, FLAG_FAILSAFE);
    issue_word(sfe_pkg::ACT_FLAG, 8'd1, 16'h0000, FLAG_CH17);
    issue_word(sfe_pkg::ACT_RAW, 8'd9, 16'h0AAA, FLAG_CH17);
    issue_word(sfe_pkg::ACT_SEND, 8'd0, 16'd0, FLAG_CH17);

    // Random traffic: no idling, sender gaps, receiver stalls, then both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      repeat (PHASE_WORDS) issue_random_word();
    end
    in_valid_i <= 1'b0;

    // Drain the outstanding frame words, then give the encoder time to show
    // any word it should not send.
    while (pending_words != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("sbus_frame_encoder_unit test passed");
    end else begin
      $display("sbus_frame_encoder_unit test failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/sfe_pkg.sv
sv/sbus_frame_encoder_unit.sv
dv/sbus_frame_checker.sv
dv/sbus_frame_encoder_unit_tb.sv
